FILE: rtl/osat_pkg.sv
// Shared constants, codes and controller/datapath interface types for the alarm table.
package osat_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 8;
  localparam int TICK_W   = 32;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int ENTRY_W  = TICK_W + HANDLE_W;

  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SET_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;

  typedef struct packed {
    logic capture;
    logic set_commit;
    logic rd_en;
    logic idx_inc;
    logic cancel_clr;
    logic fire;
    logic flush;
  } osat_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            match;
    logic            hit;
    logic            idx_last;
    logic            pend_valid;
    logic            out_free;
  } osat_stat_t;

endpackage

FILE: rtl/osat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module osat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/osat_dp.sv
// Datapath: item registers, valid bits, slot RAM, scan index, pending and output registers.
module osat_dp import osat_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [TICK_W-1:0]   in_period,
  input  logic [TICK_W-1:0]   in_now,
  input  osat_cmd_t           cmd,
  output osat_stat_t          stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [KIND_W-1:0]   out_kind,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [HANDLE_W-1:0] out_fired_handle,
  output logic                out_last
);

  logic [OP_W-1:0]     op_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TICK_W-1:0]   period_r;
  logic [TICK_W-1:0]   now_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;

  logic                pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]    pend_idx_r;
  logic [HANDLE_W-1:0] pend_handle_r;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_last_r, out_last_nxt;

  logic [IDX_W-1:0]    free_idx;
  logic                full;
  logic                out_free;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [TICK_W-1:0]   rd_deadline;
  logic [HANDLE_W-1:0] rd_handle;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign full      = &valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign ram_we    = cmd.set_commit && !full;
  assign ram_wdata = {now_r + period_r, handle_r};

  osat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_deadline = ram_rdata[ENTRY_W-1:HANDLE_W];
  assign rd_handle   = ram_rdata[HANDLE_W-1:0];

  assign stat.op         = op_r;
  assign stat.match      = valid_r[idx_r] && (rd_handle == handle_r);
  assign stat.hit        = valid_r[idx_r] && (rd_deadline <= now_r) &&
                           (cnt_r < CNT_W'(MAX_RESULTS));
  assign stat.idx_last   = (idx_r == IDX_W'(SLOTS - 1));
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  always_comb begin
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;

    if (cmd.capture) begin
      idx_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end

    if (cmd.set_commit) begin
      out_valid_nxt  = 1'b1;
      out_handle_nxt = handle_r;
      out_last_nxt   = 1'b1;
      if (full) begin
        out_kind_nxt = KIND_SET_FULL;
        out_slot_nxt = '0;
      end else begin
        out_kind_nxt        = KIND_SET_OK;
        out_slot_nxt        = SLOT_W'(free_idx);
        valid_nxt[free_idx] = 1'b1;
      end
    end

    if (cmd.cancel_clr) begin
      valid_nxt[idx_r] = 1'b0;
    end

    if (cmd.fire) begin
      valid_nxt[idx_r] = 1'b0;
      cnt_nxt          = cnt_r + 1'b1;
      pend_valid_nxt   = 1'b1;
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_FIRED;
        out_slot_nxt   = SLOT_W'(pend_idx_r);
        out_handle_nxt = pend_handle_r;
        out_last_nxt   = 1'b0;
      end
    end

    if (cmd.flush) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_FIRED;
      out_slot_nxt   = SLOT_W'(pend_idx_r);
      out_handle_nxt = pend_handle_r;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
    end else begin
      valid_r      <= valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_opcode;
      handle_r <= in_handle;
      period_r <= in_period;
      now_r    <= in_now;
    end
    if (cmd.fire) begin
      pend_idx_r    <= idx_r;
      pend_handle_r <= rd_handle;
    end
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_slot         = out_slot_r;
  assign out_fired_handle = out_handle_r;
  assign out_last         = out_last_r;

endmodule

FILE: rtl/osat_ctrl.sv
// Controller: sequences set, cancel scan and expiry scan over the slot table.
module osat_ctrl import osat_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_opcode,
  output logic            in_ready,
  input  osat_stat_t      stat,
  output osat_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SET   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       advance;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    advance   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_opcode)
            OP_SET:    state_nxt = S_SET;
            OP_CANCEL: state_nxt = S_RD;
            OP_CHECK:  state_nxt = S_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SET: begin
        if (stat.out_free) begin
          cmd.set_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (stat.op == OP_CANCEL) begin
          cmd.cancel_clr = stat.match;
          advance        = 1'b1;
        end else if (stat.hit) begin
          // Hold while the previous hit cannot move to the output.
          if (!stat.pend_valid || stat.out_free) begin
            cmd.fire = 1'b1;
            advance  = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (stat.idx_last) begin
            state_nxt = (stat.op == OP_CHECK) ? S_FLUSH : S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/one_shot_alarm_table.sv
// Top level of the one-shot alarm table: controller, datapath and checks.
//
//   channel  direction  transfer when          payload
//   in_      input      in_valid & in_ready    opcode, handle, period, now
//   out_     output     out_valid & out_ready  kind, slot, fired_handle, last
//
// One item at a time: a set is accepted, then committed into the lowest free slot; cancel
// and check walk the slots in turn through the single RAM read port, a read state then an
// evaluate state per slot, and a check ends in a flush state. Reset (rst_n low) clears
// synchronously the valid bits, pending and output valid, index, count and state; slot
// storage is never cleared and is used only when valid. A stalled output holds its result;
// a set waits, and a check halts on its next hit, until the output is free.
module one_shot_alarm_table import osat_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [TICK_W-1:0]   in_period,
  input  logic [TICK_W-1:0]   in_now,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [HANDLE_W-1:0] out_fired_handle,
  output logic                out_last
);

  // Commands flow from the controller to the datapath, status back.
  osat_cmd_t  cmd;
  osat_stat_t stat;

  osat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps each fired slot in a pending register until the next
  // hit or the end of the scan shows whether it is the last of the run.
  osat_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_handle        (in_handle),
    .in_period        (in_period),
    .in_now           (in_now),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_fired_handle (out_fired_handle),
    .out_last         (out_last)
  );

  // A pending hit must never be overwritten while the output is still occupied.
  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire && stat.pend_valid) |-> stat.out_free)
    else $error("fire would drop a pending result");

  // No new item is taken while a fired result is still pending.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.pend_valid)
    else $error("input ready with a pending result");

  // Flush only moves a real pending result into a free output register.
  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (stat.pend_valid && stat.out_free))
    else $error("flush without pending result or output room");

  // A set result is loaded only when the output can take it.
  a_set_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_commit |-> stat.out_free)
    else $error("set result would overwrite the output");

  // A set or flush result is visible in the next cycle.
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.set_commit || cmd.flush) |=> out_valid)
    else $error("loaded result not presented");

endmodule
